// ----- rtl/pnfe_pkg.sv -----
// shared types, codes and defaults of the petri net firing engine
// no dependencies
package pnfe_pkg;

  localparam int unsigned PLACE_SLOTS_DEF      = 16;
  localparam int unsigned TRANSITION_SLOTS_DEF = 16;
  localparam int unsigned ARC_SLOTS_DEF        = 64;
  localparam int unsigned TOKEN_BITS_DEF       = 16;

  typedef enum logic [2:0] {
    REQ_LOAD_PLACE = 3'd0,
    REQ_LOAD_ARC   = 3'd1,
    REQ_FIRE       = 3'd2,
    REQ_SWEEP      = 3'd3,
    REQ_ENABLED    = 3'd4,
    REQ_READ       = 3'd5,
    REQ_DEADLOCK   = 3'd6,
    REQ_SET        = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_ZERO_WT   = 3'd3,
    ST_NOT_EN    = 3'd4,
    ST_OVER_CAP  = 3'd5
  } status_e;

  localparam logic [1:0] KIND_IN  = 2'd0;
  localparam logic [1:0] KIND_OUT = 2'd1;
  localparam logic [1:0] KIND_INH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RDPL,
    S_ARC_RD,
    S_ARC_EV,
    S_PL_EV,
    S_WEND,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    WALK_CHECK,
    WALK_CONSUME,
    WALK_PRODUCE
  } walk_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  place_index;
    logic [3:0]  transition_index;
    logic [1:0]  arc_kind;
    logic [15:0] arc_weight;
    logic [15:0] token_value;
    logic [15:0] place_capacity;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        flag;
    logic [15:0] value;
  } out_t;

  typedef struct packed {
    logic [3:0]  place;
    logic [3:0]  trans;
    logic [1:0]  kind;
    logic [15:0] weight;
  } arc_t;

endpackage

// ----- rtl/pnfe_tok_alu.sv -----
// token arithmetic for one arc: enabling compare, saturating consume,
// capacity clamped produce; uses pnfe_pkg types only by width
module pnfe_tok_alu #(
  parameter int unsigned TOKEN_BITS = pnfe_pkg::TOKEN_BITS_DEF
) (
  input  logic [TOKEN_BITS-1:0] tok_i,
  input  logic [TOKEN_BITS-1:0] cap_i,
  input  logic [15:0]           weight_i,
  output logic                  below_o,
  output logic [TOKEN_BITS-1:0] consume_o,
  output logic [TOKEN_BITS-1:0] produce_o
);
  import pnfe_pkg::*;

  localparam logic [32:0] TokMax = 33'((64'd1 << TOKEN_BITS) - 64'd1);

  logic [32:0] tok_w, cap_w, wt_w, diff_w, sum_w, clamp_w;

  always_comb begin
    tok_w = 33'(tok_i);
    cap_w = 33'(cap_i);
    wt_w  = 33'(weight_i);
    below_o = tok_w < wt_w;
    diff_w = below_o ? 33'd0 : tok_w - wt_w;
    consume_o = diff_w[TOKEN_BITS-1:0];
    sum_w = tok_w + wt_w;
    clamp_w = sum_w;
    if (cap_w != 33'd0 && sum_w > cap_w) begin
      clamp_w = cap_w;
    end
    if (clamp_w > TokMax) begin
      clamp_w = TokMax;
    end
    produce_o = clamp_w[TOKEN_BITS-1:0];
  end

endmodule

// ----- rtl/petri_net_firing_engine.sv -----
// petri net firing engine top level: place and arc memories, sequencer
// depends on pnfe_pkg and pnfe_tok_alu
//
// One request is taken at a time and answered with exactly one beat. Loads,
// reads and sets need no walk of the arc table. Fire, enabled test, sweep and
// deadlock test walk the arc table through a single-port place memory and
// an arc memory with separate read and write ports: each arc is read, and
// one that touches the transition also reads its place. Enabled test is one
// walk, fire is up to three; a sweep checks each transition in turn and fires
// it when enabled, and a deadlock test checks them until one is enabled.
// A new request can be taken while the previous answer waits on the output.
module petri_net_firing_engine #(
  parameter int unsigned PLACE_SLOTS      = pnfe_pkg::PLACE_SLOTS_DEF,
  parameter int unsigned TRANSITION_SLOTS = pnfe_pkg::TRANSITION_SLOTS_DEF,
  parameter int unsigned ARC_SLOTS        = pnfe_pkg::ARC_SLOTS_DEF,
  parameter int unsigned TOKEN_BITS       = pnfe_pkg::TOKEN_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [4:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pnfe_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pnfe_pkg::out_t  out_data_o
);
  import pnfe_pkg::*;

  localparam int unsigned PAW = $clog2(PLACE_SLOTS);
  localparam int unsigned PCW = $clog2(PLACE_SLOTS + 1);
  localparam int unsigned AAW = $clog2(ARC_SLOTS);
  localparam int unsigned ACW = $clog2(ARC_SLOTS + 1);
  localparam int unsigned TB  = TOKEN_BITS;
  localparam logic [32:0] TokMax = 33'((64'd1 << TOKEN_BITS) - 64'd1);

  // memories
  logic [2*TB-1:0] place_mem [PLACE_SLOTS];
  arc_t            arc_mem   [ARC_SLOTS];

  logic            pm_re, pm_we;
  logic [PAW-1:0]  pm_addr;
  logic [2*TB-1:0] pm_wdata, pm_rdata_q;
  logic            am_re, am_we;
  logic [AAW-1:0]  am_raddr, am_waddr;
  arc_t            am_wdata, am_rdata_q;

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      place_mem[pm_addr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rdata_q <= place_mem[pm_addr];
    end
    if (am_we) begin
      arc_mem[am_waddr] <= am_wdata;
    end
    if (am_re) begin
      am_rdata_q <= arc_mem[am_raddr];
    end
  end

  // control registers
  state_e          state_q, state_d;
  walk_e           mode_q, mode_d;
  in_t             req_q, req_d;
  logic [4:0]      tiu_q, t_q, t_d;
  logic [ACW-1:0]  i_q, i_d, arc_cnt_q, arc_cnt_d;
  logic [PCW-1:0]  pl_cnt_q, pl_cnt_d;
  logic            en_q, en_d;
  logic [5:0]      cnt_q, cnt_d, cnt_inc;
  out_t            res_q, res_d, out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // shared conditions
  logic [31:0]     pl_ext, apl_ext;
  logic [PAW-1:0]  pl_addr, apl_addr;
  logic            tr_ok, pl_ok, arc_end, t_last, tlim_zero, slot_free;
  logic            arc_match, chk_fail;
  logic [5:0]      t_nx;
  logic [TB-1:0]   cur_tok, cur_cap, cons_tok, prod_tok;
  logic            below;
  logic [32:0]     ld_cap, ld_tok, set_tok;
  logic [31:0]     rd_ext;

  assign pl_ext    = 32'(req_q.place_index);
  assign pl_addr   = pl_ext[PAW-1:0];
  assign apl_ext   = 32'(am_rdata_q.place);
  assign apl_addr  = apl_ext[PAW-1:0];
  assign tr_ok     = (32'(req_q.transition_index) < 32'(tiu_q)) &&
                     (32'(req_q.transition_index) < TRANSITION_SLOTS);
  assign pl_ok     = 32'(req_q.place_index) < 32'(pl_cnt_q);
  assign arc_end   = i_q == arc_cnt_q;
  assign t_nx      = {1'b0, t_q} + 6'd1;
  assign t_last    = (32'(t_nx) >= 32'(tiu_q)) || (32'(t_nx) >= TRANSITION_SLOTS);
  assign tlim_zero = tiu_q == 5'd0;
  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_inc   = cnt_q + 6'd1;
  assign cur_tok   = pm_rdata_q[TB-1:0];
  assign cur_cap   = pm_rdata_q[2*TB-1:TB];
  assign rd_ext    = 32'(cur_tok);

  always_comb begin
    arc_match = {1'b0, am_rdata_q.trans} == t_q;
    unique case (mode_q)
      WALK_CHECK:   arc_match = arc_match &&
                                (am_rdata_q.kind == KIND_IN || am_rdata_q.kind == KIND_INH);
      WALK_CONSUME: arc_match = arc_match && am_rdata_q.kind == KIND_IN;
      WALK_PRODUCE: arc_match = arc_match && am_rdata_q.kind == KIND_OUT;
      default:      arc_match = 1'b0;
    endcase
  end

  assign chk_fail = (am_rdata_q.kind == KIND_IN && below) ||
                    (am_rdata_q.kind == KIND_INH && !below);

  always_comb begin
    ld_cap = 33'(req_q.place_capacity);
    if (ld_cap > TokMax) begin
      ld_cap = TokMax;
    end
    ld_tok = 33'(req_q.token_value);
    if (ld_tok > TokMax) begin
      ld_tok = TokMax;
    end
    set_tok = ld_tok;
    if (ld_cap != 33'd0 && ld_tok > ld_cap) begin
      ld_tok = ld_cap;
    end
  end

  pnfe_tok_alu #(
    .TOKEN_BITS(TOKEN_BITS)
  ) u_alu (
    .tok_i    (cur_tok),
    .cap_i    (cur_cap),
    .weight_i (am_rdata_q.weight),
    .below_o  (below),
    .consume_o(cons_tok),
    .produce_o(prod_tok)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_e'(req_q.req_type))
          REQ_LOAD_PLACE, REQ_LOAD_ARC: state_d = S_DONE;
          REQ_FIRE, REQ_ENABLED:        state_d = tr_ok ? S_ARC_RD : S_DONE;
          REQ_SWEEP, REQ_DEADLOCK:      state_d = tlim_zero ? S_DONE : S_ARC_RD;
          REQ_READ, REQ_SET:            state_d = pl_ok ? S_RDPL : S_DONE;
          default:                      state_d = S_DONE;
        endcase
      end
      S_RDPL:   state_d = S_DONE;
      S_ARC_RD: state_d = arc_end ? S_WEND : S_ARC_EV;
      S_ARC_EV: state_d = arc_match ? S_PL_EV : S_ARC_RD;
      S_PL_EV:  state_d = (mode_q == WALK_CHECK && chk_fail) ? S_WEND : S_ARC_RD;
      S_WEND: begin
        state_d = S_ARC_RD;
        unique case (mode_q)
          WALK_CHECK: begin
            unique case (req_e'(req_q.req_type))
              REQ_ENABLED:  state_d = S_DONE;
              REQ_FIRE:     state_d = en_q ? S_ARC_RD : S_DONE;
              REQ_SWEEP:    state_d = (en_q || !t_last) ? S_ARC_RD : S_DONE;
              REQ_DEADLOCK: state_d = (en_q || t_last) ? S_DONE : S_ARC_RD;
              default:      state_d = S_DONE;
            endcase
          end
          WALK_CONSUME: state_d = S_ARC_RD;
          WALK_PRODUCE: begin
            state_d = (req_e'(req_q.req_type) == REQ_SWEEP && !t_last) ? S_ARC_RD : S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    req_d       = req_q;
    mode_d      = mode_q;
    t_d         = t_q;
    i_d         = i_q;
    en_d        = en_q;
    cnt_d       = cnt_q;
    pl_cnt_d    = pl_cnt_q;
    arc_cnt_d   = arc_cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pm_re       = 1'b0;
    pm_we       = 1'b0;
    pm_addr     = pl_addr;
    pm_wdata    = pm_rdata_q;
    am_re       = 1'b0;
    am_we       = 1'b0;
    am_raddr    = i_q[AAW-1:0];
    am_waddr    = arc_cnt_q[AAW-1:0];
    am_wdata    = '{place: req_q.place_index, trans: req_q.transition_index,
                    kind: req_q.arc_kind, weight: req_q.arc_weight};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
        end
      end
      S_EXEC: begin
        res_d  = '0;
        mode_d = WALK_CHECK;
        i_d    = '0;
        en_d   = 1'b1;
        cnt_d  = '0;
        t_d    = 5'(req_q.transition_index);
        unique case (req_e'(req_q.req_type))
          REQ_LOAD_PLACE: begin
            if (32'(pl_cnt_q) >= PLACE_SLOTS) begin
              res_d.status = ST_FULL;
            end else begin
              pm_we       = 1'b1;
              pm_addr     = pl_cnt_q[PAW-1:0];
              pm_wdata    = {ld_cap[TB-1:0], ld_tok[TB-1:0]};
              res_d.value = 16'(pl_cnt_q);
              pl_cnt_d    = pl_cnt_q + 1'b1;
            end
          end
          REQ_LOAD_ARC: begin
            if (32'(arc_cnt_q) >= ARC_SLOTS) begin
              res_d.status = ST_FULL;
            end else if (!pl_ok || !tr_ok) begin
              res_d.status = ST_BAD_INDEX;
            end else if (req_q.arc_weight == 16'd0) begin
              res_d.status = ST_ZERO_WT;
            end else begin
              am_we       = 1'b1;
              res_d.value = 16'(arc_cnt_q);
              arc_cnt_d   = arc_cnt_q + 1'b1;
            end
          end
          REQ_FIRE, REQ_ENABLED: begin
            if (!tr_ok) begin
              res_d.status = ST_BAD_INDEX;
            end
          end
          REQ_SWEEP: t_d = '0;
          REQ_DEADLOCK: begin
            t_d = '0;
            res_d.flag = tlim_zero;
          end
          REQ_READ, REQ_SET: begin
            if (pl_ok) begin
              pm_re = 1'b1;
            end else begin
              res_d.status = ST_BAD_INDEX;
            end
          end
          default: res_d = '0;
        endcase
      end
      S_RDPL: begin
        if (req_e'(req_q.req_type) == REQ_READ) begin
          res_d.value = rd_ext[15:0];
        end else if (cur_cap != '0 && set_tok > 33'(cur_cap)) begin
          res_d.status = ST_OVER_CAP;
        end else begin
          pm_we    = 1'b1;
          pm_wdata = {cur_cap, set_tok[TB-1:0]};
        end
      end
      S_ARC_RD: begin
        am_re = !arc_end;
      end
      S_ARC_EV: begin
        if (arc_match) begin
          pm_re   = 1'b1;
          pm_addr = apl_addr;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_PL_EV: begin
        i_d     = i_q + 1'b1;
        pm_addr = apl_addr;
        unique case (mode_q)
          WALK_CHECK: begin
            if (chk_fail) begin
              en_d = 1'b0;
            end
          end
          WALK_CONSUME: begin
            pm_we    = 1'b1;
            pm_wdata = {cur_cap, cons_tok};
          end
          WALK_PRODUCE: begin
            pm_we    = 1'b1;
            pm_wdata = {cur_cap, prod_tok};
          end
          default: pm_we = 1'b0;
        endcase
      end
      S_WEND: begin
        i_d = '0;
        unique case (mode_q)
          WALK_CHECK: begin
            unique case (req_e'(req_q.req_type))
              REQ_ENABLED: res_d.flag = en_q;
              REQ_FIRE: begin
                if (en_q) begin
                  mode_d = WALK_CONSUME;
                end else begin
                  res_d.status = ST_NOT_EN;
                end
              end
              REQ_SWEEP: begin
                if (en_q) begin
                  mode_d = WALK_CONSUME;
                end else if (!t_last) begin
                  t_d  = t_nx[4:0];
                  en_d = 1'b1;
                end else begin
                  res_d.flag  = cnt_q != 6'd0;
                  res_d.value = 16'(cnt_q);
                end
              end
              REQ_DEADLOCK: begin
                if (en_q) begin
                  res_d.flag = 1'b0;
                end else if (!t_last) begin
                  t_d  = t_nx[4:0];
                  en_d = 1'b1;
                end else begin
                  res_d.flag = 1'b1;
                end
              end
              default: res_d = res_q;
            endcase
          end
          WALK_CONSUME: mode_d = WALK_PRODUCE;
          WALK_PRODUCE: begin
            if (req_e'(req_q.req_type) == REQ_SWEEP) begin
              cnt_d       = cnt_inc;
              res_d.flag  = 1'b1;
              res_d.value = 16'(cnt_inc);
              mode_d      = WALK_CHECK;
              t_d         = t_nx[4:0];
              en_d        = 1'b1;
            end else begin
              res_d.flag = 1'b1;
            end
          end
          default: mode_d = WALK_CHECK;
        endcase
      end
      S_DONE: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= WALK_CHECK;
      tiu_q       <= '0;
      pl_cnt_q    <= '0;
      arc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pl_cnt_q    <= pl_cnt_d;
      arc_cnt_q   <= arc_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        tiu_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    t_q   <= t_d;
    i_q   <= i_d;
    en_q  <= en_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_place_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pl_cnt_q) <= PLACE_SLOTS) else $error("place count overflow");
  a_arc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(arc_cnt_q) <= ARC_SLOTS) else $error("arc count overflow");
  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ARC_EV || state_q == S_PL_EV) |-> i_q < arc_cnt_q)
    else $error("arc walk past loaded arcs");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> state_q == S_DONE)
    else $error("result dropped while output busy");
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pm_re && pm_we)) else $error("place memory read and write together");
`endif

endmodule
